FILE: rtl/core/crast_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the circle rasteriser core.
package crast_pkg;

	localparam int COORD_BITS  = 16;
	localparam int RADIUS_BITS = 14;
	localparam int OUT_BITS    = COORD_BITS + 1;
	localparam int DEC_BITS    = RADIUS_BITS + 3;
	localparam int QDEPTH      = 2;
	localparam int QAW         = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW         = $clog2(QDEPTH + 1);
	localparam int IDX_BITS    = 3;

	localparam logic signed [DEC_BITS-1:0] DEC_ONE = DEC_BITS'(1);

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	localparam logic [IDX_BITS-1:0] LAST_IDLE    = IDX_BITS'(0);
	localparam logic [IDX_BITS-1:0] LAST_FILL    = IDX_BITS'(3);
	localparam logic [IDX_BITS-1:0] LAST_OUTLINE = IDX_BITS'(7);

	// one step's worth of work handed from front to back
	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [RADIUS_BITS-1:0]       c;
		logic [RADIUS_BITS-1:0]       r;
		logic                         filled;
		logic                         done;
		logic                         idle;
	} job_t;

endpackage
`default_nettype wire

FILE: rtl/core/crast_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Front end: takes words, holds circle state, runs the decision update, issues jobs.
module crast_front (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    push,
	output logic                                         full,
	input  wire logic                                    opcode,
	input  wire logic signed [crast_pkg::COORD_BITS-1:0] center_x,
	input  wire logic signed [crast_pkg::COORD_BITS-1:0] center_y,
	input  wire logic [crast_pkg::RADIUS_BITS-1:0]       radius,
	input  wire logic                                    fill_mode,
	output logic                                         job_push,
	output crast_pkg::job_t                              job,
	input  wire logic                                    job_full
);

	logic signed [crast_pkg::COORD_BITS-1:0] cx_q, cy_q;
	logic [crast_pkg::RADIUS_BITS-1:0]       rad_q, c_q, r_q;
	logic signed [crast_pkg::DEC_BITS-1:0]   dec_q, dec_n;
	logic signed [crast_pkg::DEC_BITS-1:0]   c_e, r_e, rad_e, nc, nr;
	logic                                    filled_q, active_q;
	logic                                    take, step, done;

	assign full = job_full;
	assign take = push && !job_full;
	assign step = take && (opcode == crast_pkg::OP_STEP) && active_q;

	assign c_e   = signed'(crast_pkg::DEC_BITS'(c_q));
	assign r_e   = signed'(crast_pkg::DEC_BITS'(r_q));
	assign rad_e = signed'(crast_pkg::DEC_BITS'(rad_q));

	always_comb begin
		if (dec_q >= (c_e <<< 1)) begin
			dec_n = dec_q - (c_e <<< 1) - crast_pkg::DEC_ONE;
			nc    = c_e + crast_pkg::DEC_ONE;
			nr    = r_e;
		end else if (dec_q < ((rad_e - r_e) <<< 1)) begin
			dec_n = dec_q + (r_e <<< 1) - crast_pkg::DEC_ONE;
			nc    = c_e;
			nr    = r_e - crast_pkg::DEC_ONE;
		end else begin
			dec_n = dec_q + ((r_e - c_e - crast_pkg::DEC_ONE) <<< 1);
			nc    = c_e + crast_pkg::DEC_ONE;
			nr    = r_e - crast_pkg::DEC_ONE;
		end
	end

	assign done = nr < nc;

	always_comb begin
		job.x      = cx_q;
		job.y      = cy_q;
		job.c      = c_q;
		job.r      = r_q;
		job.filled = filled_q;
		job.done   = done;
		job.idle   = !active_q;
	end

	assign job_push = take && (opcode == crast_pkg::OP_STEP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			rad_q    <= '0;
			c_q      <= '0;
			r_q      <= '0;
			dec_q    <= '0;
			filled_q <= 1'b0;
			active_q <= 1'b0;
		end else if (take && (opcode == crast_pkg::OP_START)) begin
			cx_q     <= center_x;
			cy_q     <= center_y;
			rad_q    <= radius;
			c_q      <= '0;
			r_q      <= radius;
			dec_q    <= signed'(crast_pkg::DEC_BITS'(radius)) - crast_pkg::DEC_ONE;
			filled_q <= fill_mode;
			active_q <= 1'b1;
		end else if (step) begin
			c_q   <= nc[crast_pkg::RADIUS_BITS-1:0];
			r_q   <= nr[crast_pkg::RADIUS_BITS-1:0];
			dec_q <= dec_n;
			if (done) begin
				active_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/crast_jobq.sv
`timescale 1ns / 1ps
`default_nettype none
// Short job queue between front and back end.
module crast_jobq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire crast_pkg::job_t wr_job,
	output logic                 q_full,
	input  wire logic            rd_en,
	output crast_pkg::job_t      rd_job,
	output logic                 q_valid
);

	crast_pkg::job_t                mem_q [crast_pkg::QDEPTH];
	logic [crast_pkg::QAW-1:0]      wp_q, rp_q;
	logic [crast_pkg::QCW-1:0]      cnt_q;
	logic                           do_wr, do_rd;

	assign q_full  = cnt_q == crast_pkg::QCW'(crast_pkg::QDEPTH);
	assign q_valid = cnt_q != '0;
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && q_valid;
	assign rd_job  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == crast_pkg::QAW'(crast_pkg::QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == crast_pkg::QAW'(crast_pkg::QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/crast_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Back end: expands each job into points or spans, one result word per cycle while results are popped.
module crast_back (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 job_valid,
	input  wire crast_pkg::job_t                      job,
	output logic                                      job_pop,
	output logic                                      empty,
	input  wire logic                                 pop,
	output logic signed [crast_pkg::OUT_BITS-1:0]     x_left,
	output logic signed [crast_pkg::OUT_BITS-1:0]     x_right,
	output logic signed [crast_pkg::OUT_BITS-1:0]     y_row,
	output logic                                      valid_res,
	output logic                                      last_of_step,
	output logic                                      circle_done
);

	logic [crast_pkg::IDX_BITS-1:0]        idx_q, last_idx;
	logic                                  out_v_q, load, last;
	logic signed [crast_pkg::OUT_BITS-1:0] x_e, y_e, c_e, r_e;
	logic signed [crast_pkg::OUT_BITS-1:0] xpc, xmc, xpr, xmr, ypc, ymc, ypr, ymr;
	logic signed [crast_pkg::OUT_BITS-1:0] xl_n, xr_n, y_n;

	assign x_e = crast_pkg::OUT_BITS'(job.x);
	assign y_e = crast_pkg::OUT_BITS'(job.y);
	assign c_e = signed'(crast_pkg::OUT_BITS'(job.c));
	assign r_e = signed'(crast_pkg::OUT_BITS'(job.r));

	assign xpc = x_e + c_e;
	assign xmc = x_e - c_e;
	assign xpr = x_e + r_e;
	assign xmr = x_e - r_e;
	assign ypc = y_e + c_e;
	assign ymc = y_e - c_e;
	assign ypr = y_e + r_e;
	assign ymr = y_e - r_e;

	assign last_idx = job.idle ? crast_pkg::LAST_IDLE :
	                  job.filled ? crast_pkg::LAST_FILL : crast_pkg::LAST_OUTLINE;
	assign last     = idx_q == last_idx;
	assign load     = job_valid && (!out_v_q || pop);
	assign job_pop  = load && last;
	assign empty    = !out_v_q;

	always_comb begin
		xl_n = '0;
		xr_n = '0;
		y_n  = '0;
		if (job.idle) begin
			xl_n = '0;
		end else if (job.filled) begin
			case (idx_q)
				3'd0: begin xl_n = xmr; xr_n = xpr; y_n = ypc; end
				3'd1: begin xl_n = xmc; xr_n = xpc; y_n = ypr; end
				3'd2: begin xl_n = xmc; xr_n = xpc; y_n = ymr; end
				default: begin xl_n = xmr; xr_n = xpr; y_n = ymc; end
			endcase
		end else begin
			case (idx_q)
				3'd0: begin xl_n = xpc; y_n = ypr; end
				3'd1: begin xl_n = xpr; y_n = ypc; end
				3'd2: begin xl_n = xmc; y_n = ypr; end
				3'd3: begin xl_n = xmr; y_n = ypc; end
				3'd4: begin xl_n = xpc; y_n = ymr; end
				3'd5: begin xl_n = xpr; y_n = ymc; end
				3'd6: begin xl_n = xmc; y_n = ymr; end
				default: begin xl_n = xmr; y_n = ymc; end
			endcase
			xr_n = xl_n;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_left       <= xl_n;
			x_right      <= xr_n;
			y_row        <= y_n;
			valid_res    <= !job.idle;
			last_of_step <= last;
			circle_done  <= last && !job.idle && job.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
				idx_q   <= last ? '0 : idx_q + 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/circle_rasterizer_core.sv
// Top level of the circle rasteriser: front end, job queue and back end.
// A step word is written into the job queue as a job; the back end registers its results.
// The back end gives one result word per cycle while results are popped; an outline step
// yields 8 words, a fill step 4, an idle step 1; a start word yields nothing.
// The front end takes a word every cycle while the two-entry job queue has room.
// Reset (arst_n low) clears circle state, queue pointers and the output valid flag at once.
`timescale 1ns / 1ps
`default_nettype none
module circle_rasterizer_core (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    push,
	output logic                                         full,
	input  wire logic                                    opcode,
	input  wire logic signed [crast_pkg::COORD_BITS-1:0] center_x,
	input  wire logic signed [crast_pkg::COORD_BITS-1:0] center_y,
	input  wire logic [crast_pkg::RADIUS_BITS-1:0]       radius,
	input  wire logic                                    fill_mode,
	output logic                                         empty,
	input  wire logic                                    pop,
	output logic signed [crast_pkg::OUT_BITS-1:0]        x_left,
	output logic signed [crast_pkg::OUT_BITS-1:0]        x_right,
	output logic signed [crast_pkg::OUT_BITS-1:0]        y_row,
	output logic                                         valid_res,
	output logic                                         last_of_step,
	output logic                                         circle_done
);

	crast_pkg::job_t wr_job, rd_job;
	logic            job_push, job_full, job_valid, job_pop;

	crast_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.opcode    (opcode),
		.center_x  (center_x),
		.center_y  (center_y),
		.radius    (radius),
		.fill_mode (fill_mode),
		.job_push  (job_push),
		.job       (wr_job),
		.job_full  (job_full)
	);

	crast_jobq u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_job  (wr_job),
		.q_full  (job_full),
		.rd_en   (job_pop),
		.rd_job  (rd_job),
		.q_valid (job_valid)
	);

	crast_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job          (rd_job),
		.job_pop      (job_pop),
		.empty        (empty),
		.pop          (pop),
		.x_left       (x_left),
		.x_right      (x_right),
		.y_row        (y_row),
		.valid_res    (valid_res),
		.last_of_step (last_of_step),
		.circle_done  (circle_done)
	);

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the circle rasteriser core: random start/step words, scored per result.

typedef struct packed {
	logic signed [crast_pkg::OUT_BITS-1:0] x_left;
	logic signed [crast_pkg::OUT_BITS-1:0] x_right;
	logic signed [crast_pkg::OUT_BITS-1:0] y_row;
	logic                                  valid;
	logic                                  last;
	logic                                  done;
} raster_word_t;

class circle_tracker;
	logic signed [crast_pkg::COORD_BITS-1:0] ctr_x;
	logic signed [crast_pkg::COORD_BITS-1:0] ctr_y;
	logic [crast_pkg::RADIUS_BITS-1:0]       rad0;
	int                                      col;
	int                                      row;
	int                                      dec;
	bit                                      fill;
	bit                                      busy;
	raster_word_t                            pending[$];
	int                                      mismatches;

	function new();
		ctr_x = '0;
		ctr_y = '0;
		rad0 = '0;
		col = 0;
		row = 0;
		dec = 0;
		fill = 1'b0;
		busy = 1'b0;
		mismatches = 0;
	endfunction

	function void add(int xl, int xr, int yr, bit valid, bit last, bit done);
		raster_word_t w;
		w.x_left = crast_pkg::OUT_BITS'(xl);
		w.x_right = crast_pkg::OUT_BITS'(xr);
		w.y_row = crast_pkg::OUT_BITS'(yr);
		w.valid = valid;
		w.last = last;
		w.done = done;
		pending.push_back(w);
	endfunction

	// Works out the result words an accepted input word causes.
	function void note_word(logic op, logic signed [crast_pkg::COORD_BITS-1:0] cx,
			logic signed [crast_pkg::COORD_BITS-1:0] cy,
			logic [crast_pkg::RADIUS_BITS-1:0] rad, logic fm);
		int x;
		int y;
		int c;
		int r;
		bit done;
		if (op == crast_pkg::OP_START) begin
			ctr_x = cx;
			ctr_y = cy;
			rad0 = rad;
			fill = fm;
			col = 0;
			row = int'(rad);
			dec = int'(rad) - 1;
			busy = 1'b1;
			return;
		end
		if (!busy) begin
			add(0, 0, 0, 1'b0, 1'b1, 1'b0);
			return;
		end
		x = int'(ctr_x);
		y = int'(ctr_y);
		c = col;
		r = row;
		if (dec >= 2 * c) begin
			dec -= 2 * c + 1;
			col = c + 1;
		end else if (dec < 2 * (int'(rad0) - r)) begin
			dec += 2 * r - 1;
			row = r - 1;
		end else begin
			dec += 2 * (r - c - 1);
			row = r - 1;
			col = c + 1;
		end
		done = row < col;
		if (done)
			busy = 1'b0;
		if (fill) begin
			add(x - r, x + r, y + c, 1'b1, 1'b0, 1'b0);
			add(x - c, x + c, y + r, 1'b1, 1'b0, 1'b0);
			add(x - c, x + c, y - r, 1'b1, 1'b0, 1'b0);
			add(x - r, x + r, y - c, 1'b1, 1'b1, done);
		end else begin
			add(x + c, x + c, y + r, 1'b1, 1'b0, 1'b0);
			add(x + r, x + r, y + c, 1'b1, 1'b0, 1'b0);
			add(x - c, x - c, y + r, 1'b1, 1'b0, 1'b0);
			add(x - r, x - r, y + c, 1'b1, 1'b0, 1'b0);
			add(x + c, x + c, y - r, 1'b1, 1'b0, 1'b0);
			add(x + r, x + r, y - c, 1'b1, 1'b0, 1'b0);
			add(x - c, x - c, y - r, 1'b1, 1'b0, 1'b0);
			add(x - r, x - r, y - c, 1'b1, 1'b1, done);
		end
	endfunction

	function void compare(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	function void check_word(raster_word_t got);
		raster_word_t want;
		if (pending.size() == 0) begin
			$error("result word with none outstanding: x_left %0d y_row %0d",
				got.x_left, got.y_row);
			mismatches++;
			return;
		end
		want = pending.pop_front();
		compare("x_left", int'(want.x_left), int'(got.x_left));
		compare("x_right", int'(want.x_right), int'(got.x_right));
		compare("y_row", int'(want.y_row), int'(got.y_row));
		compare("valid_res", int'(want.valid), int'(got.valid));
		compare("last_of_step", int'(want.last), int'(got.last));
		compare("circle_done", int'(want.done), int'(got.done));
	endfunction
endclass

module tb;
	import crast_pkg::*;

	localparam int ITEMS = 370;
	localparam int LIMIT = 400000;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          push = 1'b0;
	logic                          opcode = OP_START;
	logic signed [COORD_BITS-1:0]  center_x = '0;
	logic signed [COORD_BITS-1:0]  center_y = '0;
	logic [RADIUS_BITS-1:0]        radius = '0;
	logic                          fill_mode = 1'b0;
	logic                          pop = 1'b0;
	logic                          full;
	logic                          empty;
	logic signed [OUT_BITS-1:0]    x_left;
	logic signed [OUT_BITS-1:0]    x_right;
	logic signed [OUT_BITS-1:0]    y_row;
	logic                          valid_res;
	logic                          last_of_step;
	logic                          circle_done;

	circle_tracker tracker = new();
	int            words_sent = 0;
	int            cycles = 0;
	bit            tx_burst = 1'b0;
	bit            rx_burst = 1'b0;
	logic          hold_rx = 1'b0;

	circle_rasterizer_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.opcode(opcode),
		.center_x(center_x),
		.center_y(center_y),
		.radius(radius),
		.fill_mode(fill_mode),
		.empty(empty),
		.pop(pop),
		.x_left(x_left),
		.x_right(x_right),
		.y_row(y_row),
		.valid_res(valid_res),
		.last_of_step(last_of_step),
		.circle_done(circle_done)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_word(logic op, logic signed [COORD_BITS-1:0] cx,
			logic signed [COORD_BITS-1:0] cy, logic [RADIUS_BITS-1:0] rad, logic fm);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		opcode <= op;
		center_x <= cx;
		center_y <= cy;
		radius <= rad;
		fill_mode <= fm;
		@(posedge clk);
		while (full) @(posedge clk);
		tracker.note_word(op, cx, cy, rad, fm);
		words_sent++;
		if (words_sent % 24 == 0)
			tx_burst = ($urandom_range(0, 3) == 0);
	endtask

	task automatic send_step();
		send_word(OP_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
			RADIUS_BITS'($urandom), 1'($urandom));
	endtask

	// start word, then steps until the circle closes, max_steps runs out or ITEMS words are sent
	task automatic run_circle(logic signed [COORD_BITS-1:0] cx,
			logic signed [COORD_BITS-1:0] cy, logic [RADIUS_BITS-1:0] rad, logic fm,
			int max_steps);
		int n;
		n = 0;
		send_word(OP_START, cx, cy, rad, fm);
		while (tracker.busy && n < max_steps && words_sent < ITEMS) begin
			send_step();
			n++;
		end
	endtask

	initial begin
		int kind;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_step();
		run_circle(16'sd0, 16'sd0, 14'd0, 1'b0, 1000);
		send_step();
		run_circle(-16'sd5, 16'sd7, 14'd0, 1'b1, 1000);
		run_circle(16'sh7fff, 16'sh8000, 14'h3fff, 1'b0, 3);
		run_circle(16'sh8000, 16'sh7fff, 14'h3fff, 1'b1, 3);
		run_circle(16'sd100, -16'sd100, 14'd1, 1'b0, 1000);
		run_circle(-16'sd100, 16'sd100, 14'd3, 1'b1, 1000);

		while (words_sent < ITEMS) begin
			kind = $urandom_range(0, 19);
			if (kind < 14)
				run_circle(COORD_BITS'($urandom), COORD_BITS'($urandom),
					RADIUS_BITS'($urandom_range(0, 24)), 1'($urandom), 1000);
			else if (kind < 16)
				run_circle(COORD_BITS'($urandom), COORD_BITS'($urandom),
					RADIUS_BITS'($urandom_range(25, 60)), 1'($urandom), 1000);
			else if (kind < 18)
				run_circle(COORD_BITS'($urandom), COORD_BITS'($urandom),
					RADIUS_BITS'($urandom), 1'($urandom), int'($urandom_range(0, 5)));
			else
				send_step();
		end
		push <= 1'b0;

		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (24) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// long receiver stall so the job queue fills and full rises
	initial begin
		wait (words_sent >= 120);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (500) @(posedge clk);
		hold_rx <= 1'b0;
	end

	initial begin
		raster_word_t got;
		int gap;
		int taken;
		taken = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = rx_burst ? 0 : $urandom_range(0, 15);
			if (gap != 0 || hold_rx) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
				while (hold_rx) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			got.x_left = x_left;
			got.x_right = x_right;
			got.y_row = y_row;
			got.valid = valid_res;
			got.last = last_of_step;
			got.done = circle_done;
			tracker.check_word(got);
			taken++;
			if (taken % 32 == 0)
				rx_burst = ($urandom_range(0, 3) == 0);
		end
	end

endmodule

FILE: circle_rasterizer_core.f
rtl/core/crast_pkg.sv
rtl/core/crast_front.sv
rtl/core/crast_jobq.sv
rtl/core/crast_back.sv
rtl/core/circle_rasterizer_core.sv
tb/sv/tb.sv
